[hw/rtl/lsal_pkg.sv]
// Package for the light sensor auto-ranging / lux block.
// Holds word types, status codes, setting tables and reset constants.
// No dependencies.
package lsal_pkg;

    // APB map: one 32-bit register every 4 bytes
    localparam int unsigned ADDR_W = 3;
    localparam int unsigned DATA_W = 32;
    localparam logic REG_LOW_THR  = 1'b0;
    localparam logic REG_HIGH_THR = 1'b1;

    localparam logic [15:0] LOW_THR_RST  = 16'd1000;
    localparam logic [15:0] HIGH_THR_RST = 16'd10000;

    localparam int unsigned MAX_ATTEMPTS_DEF = 24;

    // gain index order: x1/8, x1/4, x1, x2 ; time index order: 25 ms .. 800 ms
    localparam logic [1:0] GAIN_RST = 2'd0;
    localparam logic [1:0] TOP_GAIN = 2'd3;
    localparam logic [2:0] TIME_RST = 3'd2;
    localparam logic [2:0] MID_TIME = 3'd2;
    localparam logic [2:0] TOP_TIME = 3'd5;

    // round(0.0042 * 2^24)
    localparam logic [16:0] SCALE_FRAC = 17'd70464;

    localparam logic [1:0] GAIN_CODE [4] = '{2'd2, 2'd3, 2'd0, 2'd1};
    localparam logic [2:0] GAIN_EXP  [4] = '{3'd4, 3'd3, 3'd1, 3'd0};
    localparam logic [3:0] TIME_CODE [8] = '{4'd12, 4'd8, 4'd0, 4'd1,
                                             4'd2, 4'd3, 4'd3, 4'd3};

    typedef enum logic [1:0] {
        ST_RETUNE  = 2'd0,
        ST_SETTLED = 2'd1,
        ST_LUX     = 2'd2
    } t_status;

    typedef struct packed {
        logic [15:0] ambient_raw;
        logic [15:0] white_raw;
    } t_in_word;

    typedef struct packed {
        t_status     status;
        logic [1:0]  gain_code;
        logic [3:0]  time_code;
        logic [17:0] ambient_lux;
        logic [17:0] white_lux;
    } t_out_word;

endpackage

[hw/rtl/lsal_lux_scale.sv]
// Lux scaling of one raw count: raw * 0.0042 * 2^e, rounded half up.
// Uses lsal_pkg for the scale fraction and setting tables.
module lsal_lux_scale (
    input  logic [15:0] i_raw,
    input  logic [1:0]  i_gain_idx,
    input  logic [2:0]  i_time_idx,
    output logic [17:0] o_lux
);

    logic [2:0]  time_cl;
    logic [3:0]  shift;
    logic [32:0] prod;
    logic [41:0] scaled;
    logic [41:0] rounded;

    always_comb begin
        time_cl = (i_time_idx > lsal_pkg::TOP_TIME) ? lsal_pkg::TOP_TIME : i_time_idx;
        // e = gain exponent + (5 - time index), at most 9
        shift   = {1'b0, lsal_pkg::GAIN_EXP[i_gain_idx]}
                + {1'b0, lsal_pkg::TOP_TIME - time_cl};
        prod    = {17'd0, i_raw} * {16'd0, lsal_pkg::SCALE_FRAC};
        scaled  = {9'd0, prod} << shift;
        rounded = scaled + 42'(1 << 23);
        o_lux   = rounded[41:24];
    end

endmodule

[hw/rtl/light_sensor_autorange_lux_top.sv]
// Auto-ranging controller for an ambient light sensor, with lux output.
// A result word is registered at the edge that accepts the sample word and is
//   visible on the output in the following cycle. One word per cycle while not stalled.
// The input stalls only while a result is held by a stalled output.
// Synchronous active-low reset: gain x1/8, 100 ms, attempt count and final flag
//   cleared, thresholds 1000 / 10000, output empty.
module light_sensor_autorange_lux_top #(
    parameter int unsigned MAX_ATTEMPTS = lsal_pkg::MAX_ATTEMPTS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,

    // APB register port
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [lsal_pkg::ADDR_W-1:0] paddr,
    input  logic [lsal_pkg::DATA_W-1:0] pwdata,
    output logic [lsal_pkg::DATA_W-1:0] prdata,
    output logic                        pready,

    // sample words in
    input  logic                        i_in_valid,
    output logic                        o_in_stall,
    input  lsal_pkg::t_in_word          i_in_word,

    // result words out
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output lsal_pkg::t_out_word         o_out_word
);

    // attempt counter only needs to reach MAX_ATTEMPTS: the final sample clears it
    localparam int unsigned CNT_W = $clog2(MAX_ATTEMPTS + 1);

    logic [15:0]      r_low_thr;
    logic [15:0]      r_high_thr;
    logic [1:0]       r_gain_idx, n_gain_idx;
    logic [2:0]       r_time_idx, n_time_idx;
    logic [CNT_W-1:0] r_attempt,  n_attempt;
    logic             r_final,    n_final;
    logic             r_out_valid;
    lsal_pkg::t_out_word r_out_word, n_out_word;

    logic        in_acc;
    logic        cfg_wr;
    logic [15:0] amb;
    logic        in_window;
    logic        too_dark;
    logic        at_extreme;
    logic [17:0] amb_lux;
    logic [17:0] wht_lux;

    // ---------------------------------------------------------------
    // Register port: writes decode on paddr[2] only, reads likewise
    // ---------------------------------------------------------------
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_low_thr  <= lsal_pkg::LOW_THR_RST;
            r_high_thr <= lsal_pkg::HIGH_THR_RST;
        end else if (cfg_wr) begin
            case (paddr[2])
                lsal_pkg::REG_LOW_THR:  r_low_thr  <= pwdata[15:0];
                lsal_pkg::REG_HIGH_THR: r_high_thr <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[2])
            lsal_pkg::REG_LOW_THR:  prdata = {16'd0, r_low_thr};
            lsal_pkg::REG_HIGH_THR: prdata = {16'd0, r_high_thr};
            default:                prdata = '0;
        endcase
    end

    // ---------------------------------------------------------------
    // Handshake: output register doubles as the skid stage
    // ---------------------------------------------------------------
    assign o_in_stall  = r_out_valid && i_out_stall;
    assign in_acc      = i_in_valid && !o_in_stall;
    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

    // lux is always taken at the current (unchanged) setting
    lsal_lux_scale u_amb_lux (
        .i_raw      (i_in_word.ambient_raw),
        .i_gain_idx (r_gain_idx),
        .i_time_idx (r_time_idx),
        .o_lux      (amb_lux)
    );

    lsal_lux_scale u_wht_lux (
        .i_raw      (i_in_word.white_raw),
        .i_gain_idx (r_gain_idx),
        .i_time_idx (r_time_idx),
        .o_lux      (wht_lux)
    );

    // ---------------------------------------------------------------
    // Ranging step
    // ---------------------------------------------------------------
    assign amb       = i_in_word.ambient_raw;
    assign too_dark  = amb < r_low_thr;
    // crossed thresholds make this always false
    assign in_window = !too_dark && (amb <= r_high_thr);

    always_comb begin
        n_gain_idx = r_gain_idx;
        n_time_idx = r_time_idx;
        n_attempt  = r_attempt;
        n_final    = r_final;
        at_extreme = 1'b0;
        n_out_word.status      = lsal_pkg::ST_RETUNE;
        n_out_word.ambient_lux = '0;
        n_out_word.white_lux   = '0;

        if (r_final) begin
            // final sample: report lux, restart ranging at the same setting
            n_out_word.status      = lsal_pkg::ST_LUX;
            n_out_word.ambient_lux = amb_lux;
            n_out_word.white_lux   = wht_lux;
            n_attempt              = '0;
            n_final                = 1'b0;
        end else if (in_window) begin
            n_out_word.status = lsal_pkg::ST_SETTLED;
            n_final           = 1'b1;
        end else begin
            if (too_dark) begin
                // back to 100 ms first, then gain up, then longer time
                if (r_time_idx < lsal_pkg::MID_TIME)
                    n_time_idx = lsal_pkg::MID_TIME;
                else if (r_gain_idx < lsal_pkg::TOP_GAIN)
                    n_gain_idx = r_gain_idx + 2'd1;
                else if (r_time_idx < lsal_pkg::TOP_TIME)
                    n_time_idx = r_time_idx + 3'd1;
            end else begin
                // shorter time down to 100 ms, then gain down, then shorter still
                if (r_time_idx > lsal_pkg::MID_TIME)
                    n_time_idx = r_time_idx - 3'd1;
                else if (r_gain_idx != 2'd0)
                    n_gain_idx = r_gain_idx - 2'd1;
                else if (r_time_idx != 3'd0)
                    n_time_idx = r_time_idx - 3'd1;
            end
            n_attempt  = r_attempt + CNT_W'(1);
            at_extreme = (n_gain_idx == lsal_pkg::TOP_GAIN && n_time_idx == lsal_pkg::TOP_TIME)
                      || (n_gain_idx == 2'd0 && n_time_idx == 3'd0);
            if (at_extreme || n_attempt >= CNT_W'(MAX_ATTEMPTS)) begin
                n_out_word.status = lsal_pkg::ST_SETTLED;
                n_final           = 1'b1;
            end
        end

        n_out_word.gain_code = lsal_pkg::GAIN_CODE[n_gain_idx];
        n_out_word.time_code = lsal_pkg::TIME_CODE[n_time_idx];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gain_idx  <= lsal_pkg::GAIN_RST;
            r_time_idx  <= lsal_pkg::TIME_RST;
            r_attempt   <= '0;
            r_final     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_acc) begin
                r_gain_idx <= n_gain_idx;
                r_time_idx <= n_time_idx;
                r_attempt  <= n_attempt;
                r_final    <= n_final;
            end
            if (in_acc)
                r_out_valid <= 1'b1;
            else if (!i_out_stall)
                r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc)
            r_out_word <= n_out_word;
    end

    // ---------------------------------------------------------------
    // Checks
    // ---------------------------------------------------------------
    a_final_gives_lux: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && r_final) |=> (o_out_valid && o_out_word.status == lsal_pkg::ST_LUX))
        else $error("final sample did not produce a lux word");

    a_final_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && r_final) |=> (!r_final && r_attempt == '0
                                 && $stable(r_gain_idx) && $stable(r_time_idx)))
        else $error("final sample did not restart ranging at the same setting");

    a_lux_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_word.status != lsal_pkg::ST_LUX)
            |-> (o_out_word.ambient_lux == '0 && o_out_word.white_lux == '0))
        else $error("lux fields set on a ranging word");

    a_attempt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_attempt == CNT_W'(MAX_ATTEMPTS)) |-> r_final)
        else $error("attempt limit reached without settling");

    a_settled_sets_final: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && !r_final && n_out_word.status == lsal_pkg::ST_SETTLED) |=> r_final)
        else $error("settled word without pending final sample");

endmodule
